// ----- rtl/nts_pkg.sv -----
// Shared types, character codes and constants for the numeric token scanner.
`default_nettype none
package nts_pkg;

    // Token value and line counter widths
    localparam int TOKEN_BITS = 16;
    localparam int LINE_BITS  = 16;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    // Final status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_COUNT     = 2'd2;

    typedef enum logic [1:0] {
        SCAN_BETWEEN = 2'd0,
        SCAN_WORD    = 2'd1,
        SCAN_COMMENT = 2'd2,
        SCAN_STOPPED = 2'd3
    } t_scan_phase;

    typedef enum logic [2:0] {
        WP_EMPTY  = 3'd0,
        WP_PREFIX = 3'd1,
        WP_SIGNED = 3'd2,
        WP_ZERO   = 3'd3,
        WP_X      = 3'd4,
        WP_DIGITS = 3'd5
    } t_word_phase;

    // Running scanner state
    typedef struct packed {
        t_scan_phase            scan_phase;
        t_word_phase            word_phase;
        logic                   use_hex;
        logic                   is_negative;
        logic [TOKEN_BITS-1:0]  accumulator;
        logic                   word_bad;
        logic [1:0]             count_mod_three;
        logic [LINE_BITS-1:0]   newline_count;
    } t_scan_state;

    localparam t_scan_state SCAN_STATE_RESET = '{
        scan_phase:      SCAN_BETWEEN,
        word_phase:      WP_EMPTY,
        use_hex:         1'b0,
        is_negative:     1'b0,
        accumulator:     '0,
        word_bad:        1'b0,
        count_mod_three: 2'd0,
        newline_count:   '0
    };

    // One result beat
    typedef struct packed {
        logic                   token_valid;
        logic [TOKEN_BITS-1:0]  token_value;
        logic                   done_res;
        logic [1:0]             status;
        logic [LINE_BITS-1:0]   error_line;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/nts_in_if.sv -----
// Character input channel: valid/ready handshake with one source character.
`default_nettype none
interface nts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/nts_out_if.sv -----
// Result output channel: valid/ready handshake with token and status fields.
`default_nettype none
interface nts_out_if;
    logic        valid;
    logic        ready;
    logic        token_valid;
    logic [15:0] token_value;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] error_line;

    modport source (output valid, output token_valid, output token_value,
                     output done_res, output status, output error_line, input ready);
    modport sink   (input valid, input token_valid, input token_value,
                     input done_res, input status, input error_line, output ready);
endinterface
`default_nettype wire

// ----- rtl/nts_step.sv -----
// Next-state and result logic for one source character.
`default_nettype none
module nts_step
    import nts_pkg::*;
(
    input  t_scan_state i_state,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    output t_scan_state o_state,
    output t_result     o_res,
    output logic        o_res_valid
);

    logic                  w_is_sep;
    logic                  w_dig_ok;
    logic [3:0]            w_dig;
    logic [TOKEN_BITS-1:0] w_acc_next;

    // Word separators: whitespace or comment mark
    always_comb begin
        w_is_sep = (i_char == CH_SPACE) || (i_char inside {[CH_TAB:CH_CR]}) ||
                   (i_char == CH_HASH);
    end

    // Digit decode in the current base
    always_comb begin
        w_dig_ok = 1'b0;
        w_dig    = 4'd0;
        if (i_char inside {[CH_0:CH_9]}) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(i_char - CH_0);
        end else if (i_state.use_hex && (i_char inside {[CH_LA:CH_LF_HEX]})) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(i_char - CH_LA + 8'd10);
        end else if (i_state.use_hex && (i_char inside {[CH_UA:CH_UF]})) begin
            w_dig_ok = 1'b1;
            w_dig    = 4'(i_char - CH_UA + 8'd10);
        end
    end

    // Accumulate: times 16 is a shift, times 10 is two shifted adds
    always_comb begin
        if (i_state.use_hex) begin
            w_acc_next = (i_state.accumulator << 4) | TOKEN_BITS'(w_dig);
        end else begin
            w_acc_next = (i_state.accumulator << 3) + (i_state.accumulator << 1) +
                         TOKEN_BITS'(w_dig);
        end
    end

    // Main step
    always_comb begin
        t_scan_state s;
        logic        finish;
        logic        error;
        logic        tok_ok;
        s           = i_state;
        finish      = 1'b0;
        error       = 1'b0;
        tok_ok      = 1'b0;
        o_res       = '0;
        o_res_valid = 1'b0;

        if (i_state.scan_phase == SCAN_STOPPED) begin
            if (i_last) begin
                s = SCAN_STATE_RESET;
            end
        end else begin
            if (i_state.scan_phase == SCAN_COMMENT) begin
                if (i_char == CH_LF) begin
                    s.scan_phase = SCAN_BETWEEN;
                end
            end else if (w_is_sep) begin
                // newline and '#' both count a line, saturating
                if ((i_char == CH_LF || i_char == CH_HASH) && (s.newline_count != '1)) begin
                    s.newline_count = s.newline_count + LINE_BITS'(1);
                end
                finish       = (i_state.scan_phase == SCAN_WORD);
                s.scan_phase = (i_char == CH_HASH) ? SCAN_COMMENT : SCAN_BETWEEN;
            end else begin
                s.scan_phase = SCAN_WORD;
                // feed one character into the word
                if (!i_state.word_bad) begin
                    if (i_state.word_phase == WP_EMPTY && i_char == CH_DOLLAR) begin
                        s.use_hex    = 1'b1;
                        s.word_phase = WP_PREFIX;
                    end else if ((i_state.word_phase == WP_EMPTY ||
                                  i_state.word_phase == WP_PREFIX) &&
                                 (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                        s.is_negative = (i_char == CH_MINUS);
                        s.word_phase  = WP_SIGNED;
                    end else if (i_state.word_phase == WP_ZERO &&
                                 (i_char == CH_LX || i_char == CH_UX)) begin
                        s.word_phase = WP_X;
                    end else if (!w_dig_ok) begin
                        s.word_bad = 1'b1;
                    end else if (i_state.word_phase == WP_DIGITS ||
                                 i_state.word_phase == WP_ZERO) begin
                        s.accumulator = w_acc_next;
                        s.word_phase  = WP_DIGITS;
                    end else begin
                        s.accumulator = TOKEN_BITS'(w_dig);
                        s.word_phase  = (i_state.use_hex && w_dig == 4'd0 &&
                                         i_state.word_phase != WP_X) ? WP_ZERO : WP_DIGITS;
                    end
                end
            end

            // a word still open at the end is flushed
            if (i_last && s.scan_phase == SCAN_WORD) begin
                finish = 1'b1;
            end

            if (finish) begin
                tok_ok = !s.word_bad && (s.word_phase == WP_ZERO || s.word_phase == WP_DIGITS);
                if (tok_ok) begin
                    o_res.token_valid = 1'b1;
                    o_res.token_value = s.is_negative ? (TOKEN_BITS'(0) - s.accumulator)
                                                      : s.accumulator;
                    s.count_mod_three = (s.count_mod_three == 2'd2) ? 2'd0
                                                                    : s.count_mod_three + 2'd1;
                end else begin
                    error            = 1'b1;
                    o_res.done_res   = 1'b1;
                    o_res.status     = ST_MALFORMED;
                    o_res.error_line = s.newline_count;
                end
                s.word_phase  = WP_EMPTY;
                s.use_hex     = 1'b0;
                s.is_negative = 1'b0;
                s.accumulator = '0;
                s.word_bad    = 1'b0;
            end

            if (i_last && !error) begin
                o_res.done_res   = 1'b1;
                o_res.status     = (s.count_mod_three != 2'd0) ? ST_COUNT : ST_OK;
                o_res.error_line = (s.count_mod_three != 2'd0) ? s.newline_count : '0;
            end

            o_res_valid = o_res.token_valid || o_res.done_res;

            if (i_last) begin
                s = SCAN_STATE_RESET;
            end else if (error) begin
                s.scan_phase = SCAN_STOPPED;
            end
        end
        o_state = s;
    end

endmodule
`default_nettype wire

// ----- rtl/nts_out_reg.sv -----
// Result register between the scanner logic and the output channel.
`default_nettype none
module nts_out_reg
    import nts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_can_take,
    nts_out_if.source o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Register is free when empty or when its beat leaves this cycle
    assign o_can_take = !r_valid || o_res.ready;
    assign n_valid    = i_load || (r_valid && !o_res.ready);

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.token_valid = r_res.token_valid;
    assign o_res.token_value = r_res.token_value;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.status      = r_res.status;
    assign o_res.error_line  = r_res.error_line;

endmodule
`default_nettype wire

// ----- rtl/numeric_token_scanner.sv -----
// Top level of the numeric token scanner.
//
// Input channel i_chr carries one source character per beat (char_code,
// last_char marks the end of the source). Output channel o_res carries at
// most one result per character: a completed token, a final status, or both.
// Words are decimal, or hex when they open with '$'; '#' opens a comment
// that runs to the newline. Values leave modulo 2^16.
//
// Latency: a result appears on o_res the cycle after the character that
// caused it is accepted. Throughput: one character per cycle, set by the
// single pass through the step logic into the result register.
// While a result waits in the output register and o_res.ready is low, no
// further character is taken; a character accepted in the same cycle that
// the waiting beat leaves keeps the rate at one per cycle.
// A malformed word reports status 1 with its line, then the block discards
// characters until the one marked last_char, which rearms it silently.
// Synchronous reset (i_rst_n low) returns the scan state to between-words
// with all counts cleared and empties the output register.
`default_nettype none
module numeric_token_scanner
    import nts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    nts_in_if.sink   i_chr,
    nts_out_if.source o_res
);

    t_scan_state r_state;
    t_scan_state n_state;
    t_result     w_res;
    logic        w_res_valid;
    logic        w_can_take;
    logic        w_fire;

    assign i_chr.ready = w_can_take;
    assign w_fire      = i_chr.valid && w_can_take;

    // Per-character step logic
    nts_step u_step (
        .i_state     (r_state),
        .i_char      (i_chr.char_code),
        .i_last      (i_chr.last_char),
        .o_state     (n_state),
        .o_res       (w_res),
        .o_res_valid (w_res_valid)
    );

    // Scanner state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SCAN_STATE_RESET;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // Result register
    nts_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire && w_res_valid),
        .i_res      (w_res),
        .o_can_take (w_can_take),
        .o_res      (o_res)
    );

    // A bad word is only ever held while inside that word
    a_bad_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.word_bad |-> r_state.scan_phase == SCAN_WORD)
        else $error("word_bad set outside a word");

    // Token counter stays modulo three
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count_mod_three != 2'd3)
        else $error("count_mod_three out of range");

    // The final character always rearms the scanner
    a_last_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_chr.last_char |=> r_state == SCAN_STATE_RESET)
        else $error("state not cleared after last character");

    // A stopped scanner produces no result
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scan_phase == SCAN_STOPPED |-> !w_res_valid)
        else $error("result produced while stopped");

    // Between words nothing is pending
    a_between_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scan_phase == SCAN_BETWEEN |->
            (r_state.word_phase == WP_EMPTY && r_state.accumulator == '0))
        else $error("word state left over between words");

endmodule
`default_nettype wire

// ----- tb/nts_result_checker.sv -----
// Result checker for the numeric token scanner: tracks scan state per character and checks each result beat.
`timescale 1ns / 1ps
module nts_result_checker
    import nts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    nts_in_if    i_chr,
    nts_out_if   i_res,
    output int   o_fail_count,
    output int   o_due_count,
    output int   o_result_count,
    output int   o_token_count,
    output int   o_stop_count
);

    // Mirror of the scanner state
    t_scan_phase             phase;
    t_word_phase             wphase;
    logic                    hex_word;
    logic                    neg_word;
    logic                    word_bad;
    logic [TOKEN_BITS-1:0]   acc;
    logic [1:0]              tok_mod3;
    logic [LINE_BITS-1:0]    line_count;

    // Results still owed by the block, oldest first
    t_result due_results[$];

    function automatic void clear_word();
        wphase   = WP_EMPTY;
        hex_word = 1'b0;
        neg_word = 1'b0;
        acc      = '0;
        word_bad = 1'b0;
    endfunction

    function automatic void restart_source();
        phase = SCAN_BETWEEN;
        clear_word();
        tok_mod3   = '0;
        line_count = '0;
    endfunction

    // digit value in the current base, -1 when not a digit
    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        if (hex_word && c >= CH_LA && c <= CH_LF_HEX) return c - CH_LA + 10;
        if (hex_word && c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
        return -1;
    endfunction

    // one character of a word: prefix, sign, 0x, or a digit
    function automatic void feed_word(input logic [7:0] c);
        int d;
        if (word_bad) return;
        if (wphase == WP_EMPTY && c == CH_DOLLAR) begin
            hex_word = 1'b1;
            wphase   = WP_PREFIX;
            return;
        end
        if ((wphase == WP_EMPTY || wphase == WP_PREFIX) && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_word = (c == CH_MINUS);
            wphase   = WP_SIGNED;
            return;
        end
        if (wphase == WP_ZERO && (c == CH_LX || c == CH_UX)) begin
            wphase = WP_X;
            return;
        end
        d = digit_value(c);
        if (d < 0) begin
            word_bad = 1'b1;
            return;
        end
        if (wphase == WP_DIGITS || wphase == WP_ZERO) begin
            acc    = acc * (hex_word ? 16 : 10) + d;
            wphase = WP_DIGITS;
        end else begin
            wphase = (hex_word && d == 0 && wphase != WP_X) ? WP_ZERO : WP_DIGITS;
            acc    = d;
        end
    endfunction

    // Advance by one character; returns 1 when a result beat is due
    function automatic bit scan_char(input logic [7:0] c, input logic last, output t_result r);
        bit finish;
        bit stop;
        r      = '0;
        finish = 1'b0;
        stop   = 1'b0;
        if (phase == SCAN_STOPPED) begin
            if (last) restart_source();
            return 1'b0;
        end
        if (phase == SCAN_COMMENT) begin
            if (c == CH_LF) phase = SCAN_BETWEEN;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_HASH) begin
            // '#' counts its line at once, the newline closing it does not
            if ((c == CH_LF || c == CH_HASH) && line_count != '1) line_count++;
            finish = (phase == SCAN_WORD);
            phase  = (c == CH_HASH) ? SCAN_COMMENT : SCAN_BETWEEN;
        end else begin
            phase = SCAN_WORD;
            feed_word(c);
        end
        if (last && phase == SCAN_WORD) finish = 1'b1;
        if (finish) begin
            if (!word_bad && (wphase == WP_ZERO || wphase == WP_DIGITS)) begin
                r.token_valid = 1'b1;
                r.token_value = neg_word ? -acc : acc;
                tok_mod3      = (tok_mod3 == 2'd2) ? 2'd0 : tok_mod3 + 2'd1;
            end else begin
                stop         = 1'b1;
                r.done_res   = 1'b1;
                r.status     = ST_MALFORMED;
                r.error_line = line_count;
            end
            clear_word();
        end
        if (last && !stop) begin
            r.done_res   = 1'b1;
            r.status     = (tok_mod3 != 2'd0) ? ST_COUNT : ST_OK;
            r.error_line = (tok_mod3 != 2'd0) ? line_count : '0;
        end
        if (last) restart_source();
        else if (stop) phase = SCAN_STOPPED;
        return r.token_valid || r.done_res;
    endfunction

    initial begin
        o_fail_count   = 0;
        o_due_count    = 0;
        o_result_count = 0;
        o_token_count  = 0;
        o_stop_count   = 0;
    end

    // Result beats are checked before the character beat of the same edge is queued
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            restart_source();
            due_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.token_valid = i_res.token_valid;
                got.token_value = i_res.token_value;
                got.done_res    = i_res.done_res;
                got.status      = i_res.status;
                got.error_line  = i_res.error_line;
                o_result_count++;
                if (got.token_valid === 1'b1) o_token_count++;
                if (got.status === ST_MALFORMED) o_stop_count++;
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] unexpected result beat: tv=%0b val=%h done=%0b st=%0d line=%0d",
                                 $time, got.token_valid, got.token_value, got.done_res,
                                 got.status, got.error_line);
                end else begin
                    want = due_results.pop_front();
                    if (got.token_valid !== want.token_valid ||
                        got.token_value !== want.token_value ||
                        got.done_res    !== want.done_res ||
                        got.status      !== want.status ||
                        got.error_line  !== want.error_line) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] result mismatch: expected tv=%0b val=%h done=%0b ",
                                      "st=%0d line=%0d, got tv=%0b val=%h done=%0b st=%0d line=%0d"},
                                     $time, want.token_valid, want.token_value, want.done_res,
                                     want.status, want.error_line, got.token_valid,
                                     got.token_value, got.done_res, got.status, got.error_line);
                    end
                end
            end
            if (i_chr.valid && i_chr.ready) begin
                if (scan_char(i_chr.char_code, i_chr.last_char, fresh))
                    due_results.push_back(fresh);
            end
        end
        o_due_count <= due_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the numeric token scanner: stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module tb;
    import nts_pkg::*;

    localparam int RANDOM_CHARS = 1620;
    localparam int FLOOD_LINES  = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    nts_in_if  chr ();
    nts_out_if res ();

    int fail_count;
    int due_count;
    int result_count;
    int token_count;
    int stop_count;

    logic [7:0] text[$];
    int         chars_sent;
    int         sources_sent;
    int         burst_left;
    bit         gaps_on;
    bit         hold_req;

    numeric_token_scanner uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr),
        .o_res   (res)
    );

    nts_result_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_chr          (chr),
        .i_res          (res),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count),
        .o_result_count (result_count),
        .o_token_count  (token_count),
        .o_stop_count   (stop_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("tb NOT OK");
        $finish;
    end

    // Result side: random stall segments, plus one long hold-off once random traffic starts
    initial begin
        int       seg_left;
        int       hold_left;
        int       period;
        t_rx_mode mode;
        res.ready <= 1'b0;
        seg_left  = 0;
        hold_left = HOLD_CYCLES;
        period    = 2;
        mode      = RX_FREE;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 200);
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    period   = $urandom_range(2, 5);
                end
                seg_left--;
                case (mode)
                    RX_FREE:  res.ready <= 1'b1;
                    RX_LIGHT: res.ready <= ($urandom_range(0, 9) < 8);
                    RX_HEAVY: res.ready <= ($urandom_range(0, 9) < 3);
                    default:  res.ready <= (seg_left % period != 0);
                endcase
            end
        end
    end

    // One character beat, after a random gap when a burst has run out
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                chr.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        chr.valid     <= 1'b1;
        chr.char_code <= c;
        chr.last_char <= last;
        @(posedge i_clk);
        while (!chr.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
        sources_sent++;
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_digit(input int v, input bit upper);
        if (v < 10) return CH_0 + v;
        return (upper ? CH_UA : CH_LA) + v - 10;
    endfunction

    function automatic void add_sign();
        case ($urandom_range(0, 3))
            1: text.push_back(CH_PLUS);
            2: text.push_back(CH_MINUS);
            default: ;
        endcase
    endfunction

    // Mostly well-formed words, some without digits or with a stray byte
    function automatic void add_word();
        int         kind;
        int         n;
        int         pos;
        logic [7:0] b;
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
            add_sign();
            n = $urandom_range(1, 7);
            repeat (n) text.push_back(CH_0 + $urandom_range(0, 9));
        end else if (kind < 16) begin
            text.push_back(CH_DOLLAR);
            add_sign();
            if ($urandom_range(0, 1)) begin
                text.push_back(CH_0);
                text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            n = $urandom_range(1, 5);
            repeat (n) text.push_back(hex_digit($urandom_range(0, 15), $urandom_range(0, 1)));
        end else if (kind < 18) begin
            // words that never reach a digit
            case ($urandom_range(0, 4))
                0: text.push_back(CH_DOLLAR);
                1: text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                2: begin
                    text.push_back(CH_DOLLAR);
                    text.push_back(CH_MINUS);
                end
                3: begin
                    text.push_back(CH_DOLLAR);
                    text.push_back(CH_0);
                    text.push_back(CH_LX);
                end
                default: begin
                    text.push_back(CH_DOLLAR);
                    text.push_back(CH_PLUS);
                    text.push_back(CH_0);
                    text.push_back(CH_UX);
                end
            endcase
        end else begin
            pos = text.size();
            n   = $urandom_range(1, 4);
            repeat (n) text.push_back(CH_0 + $urandom_range(0, 9));
            do b = $urandom_range(1, 255);
            while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_HASH);
            text.insert(pos + $urandom_range(0, n), b);
        end
    endfunction

    // Whitespace run or a comment; a trailing comment may stay open
    function automatic void add_gap(input bit may_end);
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            n = (kind < 5) ? 1 : $urandom_range(2, 4);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: b = CH_SPACE;
                    3:       b = CH_LF;
                    default: b = $urandom_range(CH_TAB, CH_CR);
                endcase
                text.push_back(b);
            end
        end else begin
            text.push_back(CH_HASH);
            n = $urandom_range(0, 8);
            repeat (n) begin
                do b = $urandom_range(1, 255);
                while (b == CH_LF);
                text.push_back(b);
            end
            if (!may_end || $urandom_range(0, 1)) text.push_back(CH_LF);
        end
    endfunction

    function automatic void build_source();
        int words;
        text.delete();
        if ($urandom_range(0, 11) == 0) begin
            // raw noise over byte values 1 to 255
            repeat ($urandom_range(1, 20)) text.push_back($urandom_range(1, 255));
        end else begin
            words = 3 * $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) words += $urandom_range(1, 2);
            if ($urandom_range(0, 1)) add_gap(1'b0);
            for (int w = 0; w < words; w++) begin
                add_word();
                if (w < words - 1 || $urandom_range(0, 1)) add_gap(w == words - 1);
            end
            if (text.size() == 0) text.push_back(CH_SPACE);
        end
    endfunction

    // Stimulus and verdict
    initial begin
        int random_start;
        chr.valid     <= 1'b0;
        chr.char_code <= CH_SPACE;
        chr.last_char <= 1'b0;
        i_rst_n       <= 1'b0;
        chars_sent   = 0;
        sources_sent = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;
        hold_req     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // comment line, signed hex with 0x, pending word flushed with the count error
        load_text("#c\n$-0xF 9");
        send_text();
        // sign-only word ended by '#', then swallowed bytes up to the last one
        load_text("+#");
        text.push_back(8'hFF);
        text.push_back(8'h01);
        text.push_back("z");
        send_text();
        // high byte inside a word on the last character
        load_text("7");
        text.push_back(8'hFF);
        send_text();
        // comment running to the end of the source
        load_text("#x");
        send_text();
        // value extremes, three tokens
        load_text("0 $FFFF 1");
        send_text();

        // random sources
        hold_req     = 1'b1;
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_CHARS) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            build_source();
            send_text();
        end

        // run of newlines, then a malformed last word
        gaps_on = 1'b0;
        text.delete();
        repeat (FLOOD_LINES) text.push_back(CH_LF);
        text.push_back("7");
        text.push_back(CH_SPACE);
        text.push_back(CH_PLUS);
        send_text();

        chr.valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Scanned %0d characters in %0d sources, one of them a %0d-newline run.",
                 chars_sent, sources_sent, FLOOD_LINES);
        $display("Checked %0d result beats: %0d tokens, %0d malformed-word stops, %0d failures.",
                 result_count, token_count, stop_count, fail_count);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
